// File: sv/tea_pkg.sv
// Shared types and constants for the TEA block cipher core.
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_index_t;

  // Direction codes
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] half_first;
    logic [WORD_W-1:0] half_second;
  } tea_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_first;
    logic [WORD_W-1:0] out_second;
  } tea_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // One pipeline slot: valid bit travels with the data
  typedef struct packed {
    logic              vld;
    logic              action;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } tea_stage_t;

  function automatic logic [WORD_W-1:0] tea_mix(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// File: sv/tea_half_round.sv
// One registered half round of TEA: updates one half of the block.
module tea_half_round #(
  parameter logic [31:0] SUM_ENC = 32'h9e37_79b9,
  parameter logic [31:0] SUM_DEC = 32'h9e37_79b9,
  parameter bit          ODD     = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tea_pkg::tea_key_t   key,
  input  tea_pkg::tea_stage_t d,
  output tea_pkg::tea_stage_t q
);
  import tea_pkg::*;

  logic              upd_a;
  logic              enc;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] m;
  logic [WORD_W-1:0] tgt;
  logic [WORD_W-1:0] res;
  tea_stage_t        q_next;

  // Encrypt: even half updates a, odd updates b. Decrypt runs the other way.
  always_comb begin
    enc   = (d.action == ACT_ENCRYPT);
    upd_a = enc ^ ODD;
    x     = upd_a ? d.b : d.a;
    ka    = upd_a ? key.k0 : key.k2;
    kb    = upd_a ? key.k1 : key.k3;
    sum   = enc ? SUM_ENC : SUM_DEC;
    m     = tea_mix(x, sum, ka, kb);
    tgt   = upd_a ? d.a : d.b;
    res   = enc ? (tgt + m) : (tgt - m);
    q_next        = d;
    if (upd_a) begin
      q_next.a = res;
    end else begin
      q_next.b = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= d.vld;
    end
    if (en) begin
      q.action <= q_next.action;
      q.a      <= q_next.a;
      q.b      <= q_next.b;
    end
  end

endmodule

// File: sv/tea_block_cipher_core.sv
// TEA block cipher core: unrolled pipeline of half rounds with key registers.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------
//   in       | input     | in_valid/in_stall  | in_data  (tea_in_t)
//   out      | output    | out_valid/out_stall| out_data (tea_out_t)
//   cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// There is one register per half round (2*ROUNDS in all); one block per
// cycle is accepted while the output side takes results.
// The last half-round register is the output register. The whole pipeline
// advances when that register is empty or its transfer completes; in_stall
// is high exactly when it holds.
// Reset (synchronous) clears valid bits and the key words.
module tea_block_cipher_core #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tea_pkg::tea_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tea_pkg::tea_out_t  out_data,
  input  logic               cfg_we,
  input  tea_pkg::cfg_index_t cfg_index,
  input  logic [31:0]        cfg_data
);
  import tea_pkg::*;

  localparam int unsigned STAGES = 2 * ROUNDS;

  tea_key_t   key;
  tea_stage_t stg_in  [STAGES];
  tea_stage_t stg_out [STAGES];
  logic       adv;
  logic [STAGES-1:0] vld_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0: key.k0 <= cfg_data;
        CFG_KEY1: key.k1 <= cfg_data;
        CFG_KEY2: key.k2 <= cfg_data;
        CFG_KEY3: key.k3 <= cfg_data;
        default:  key    <= key;
      endcase
    end
  end

  assign adv      = !stg_out[STAGES-1].vld || !out_stall;
  assign in_stall = !adv;

  genvar h;
  generate
    for (h = 0; h < STAGES; h++) begin : g_stage
      localparam int unsigned RND = h / 2;
      localparam logic [63:0] PROD_ENC = 64'(RND + 1) * 64'(TEA_DELTA);
      localparam logic [63:0] PROD_DEC = 64'(ROUNDS - RND) * 64'(TEA_DELTA);

      if (h == 0) begin : g_first
        assign stg_in[h] = '{vld:    in_valid,
                             action: in_data.action,
                             a:      in_data.half_first,
                             b:      in_data.half_second};
      end else begin : g_next
        assign stg_in[h] = stg_out[h-1];
      end

      tea_half_round #(
        .SUM_ENC (PROD_ENC[31:0]),
        .SUM_DEC (PROD_DEC[31:0]),
        .ODD     (1'(h % 2))
      ) u_half (
        .clk (clk),
        .rst (rst),
        .en  (adv),
        .key (key),
        .d   (stg_in[h]),
        .q   (stg_out[h])
      );

      assign vld_vec[h] = stg_out[h].vld;
    end
  endgenerate

  assign out_valid          = stg_out[STAGES-1].vld;
  assign out_data.out_first  = stg_out[STAGES-1].a;
  assign out_data.out_second = stg_out[STAGES-1].b;

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> (vld_vec == '0))
    else $error("pipeline valid bits not cleared by reset");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld_vec))
    else $error("pipeline moved while held");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    !in_stall |=> (vld_vec[0] == $past(in_valid)))
    else $error("first stage valid does not follow accepted input");
`endif

endmodule

// File: verif/tb_tea_block_cipher_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TEA block cipher core: directed and random blocks.
module tb_tea_block_cipher_core;
  import tea_pkg::*;

  localparam int unsigned CIPHER_ROUNDS = 32;
  localparam int unsigned PIPE_DEPTH = 2 * CIPHER_ROUNDS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tea_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tea_out_t out_data;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_KEY0;
  logic [31:0] cfg_data = '0;

  // key words as the core should hold them
  logic [31:0] key0 = '0;
  logic [31:0] key1 = '0;
  logic [31:0] key2 = '0;
  logic [31:0] key3 = '0;

  tea_in_t pending_blocks[$];
  tea_out_t expected_blocks[$];
  tea_out_t want;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned errors = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  bit idle_on = 1'b1;

  tea_block_cipher_core #(
    .ROUNDS(CIPHER_ROUNDS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] round_f(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] sh_l, sh_r;
    sh_l = {x[27:0], 4'b0000};
    sh_r = {5'b00000, x[31:5]};
    return (sh_l + ka) ^ (x + sum) ^ (sh_r + kb);
  endfunction

  // Full 32-round transform of one block with the current key words
  function automatic tea_out_t cipher_block(input tea_in_t blk);
    logic [31:0] a, b, sum;
    tea_out_t res;
    a = blk.half_first;
    b = blk.half_second;
    if (blk.action == ACT_ENCRYPT) begin
      sum = '0;
      repeat (CIPHER_ROUNDS) begin
        sum = sum + TEA_DELTA;
        a = a + round_f(b, sum, key0, key1);
        b = b + round_f(a, sum, key2, key3);
      end
    end else begin
      sum = TEA_DELTA * CIPHER_ROUNDS;
      repeat (CIPHER_ROUNDS) begin
        b = b - round_f(a, sum, key2, key3);
        a = a - round_f(b, sum, key0, key1);
        sum = sum - TEA_DELTA;
      end
    end
    res.out_first = a;
    res.out_second = b;
    return res;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned pct);
    int unsigned r;
    if (!idle_on || $urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_block(input logic act, input logic [31:0] a,
                                     input logic [31:0] b);
    tea_in_t blk;
    blk.action = act;
    blk.half_first = a;
    blk.half_second = b;
    pending_blocks.push_back(blk);
    queued_cnt++;
  endfunction

  // Random blocks; some are followed by the inverse operation on their own result
  function automatic void add_random(input int unsigned n);
    tea_in_t blk;
    tea_out_t res;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      blk.action = 1'($urandom_range(0, 1));
      blk.half_first = rand_word();
      blk.half_second = rand_word();
      push_block(blk.action, blk.half_first, blk.half_second);
      if ($urandom_range(0, 3) == 0) begin
        res = cipher_block(blk);
        push_block(~blk.action, res.out_first, res.out_second);
      end
    end
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic load_key(input logic [31:0] w0, input logic [31:0] w1,
                          input logic [31:0] w2, input logic [31:0] w3);
    write_reg(CFG_KEY0, w0);
    write_reg(CFG_KEY1, w1);
    write_reg(CFG_KEY2, w2);
    write_reg(CFG_KEY3, w3);
    @(posedge clk);
    cfg_we <= 1'b0;
    key0 = w0;
    key1 = w1;
    key2 = w2;
    key3 = w3;
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(cipher_block(in_data));
        accepted_cnt++;
        in_gap = draw_gap(40);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          in_data <= pending_blocks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected transfer: first=%h second=%h", $time,
                   out_data.out_first, out_data.out_second);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_data.out_first !== want.out_first ||
              out_data.out_second !== want.out_second) begin
            $display("%0t: mismatch: expected first=%h second=%h, got first=%h second=%h",
                     $time, want.out_first, want.out_second,
                     out_data.out_first, out_data.out_second);
            errors++;
          end
        end
      end
      if (stall_left == 0) stall_left = draw_gap(20);
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // key still at its reset value
    idle_on = 1'b1;
    push_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    push_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    push_block(ACT_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_block(ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_block(ACT_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
    push_block(ACT_DECRYPT, 32'h0000_0000, 32'hffff_ffff);
    push_block(ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    push_block(ACT_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    push_block(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
    push_block(ACT_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
    drain();

    load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    push_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    push_block(ACT_ENCRYPT, 32'hffff_ffff, 32'h0000_0000);
    push_block(ACT_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
    push_block(ACT_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
    push_block(ACT_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
    push_block(ACT_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    push_block(ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    drain();

    // back-to-back transfers with no idling
    idle_on = 1'b0;
    add_random(250);
    drain();

    load_key(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
    idle_on = 1'b1;
    add_random(300);
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    idle_on = 1'b0;
    add_random(300);
    drain();

    repeat (2) begin
      load_key($urandom, $urandom, $urandom, $urandom);
      idle_on = 1'b1;
      add_random(375);
      drain();
    end

    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("[tea_block_cipher_core] OK");
    end else begin
      $display("[tea_block_cipher_core] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[tea_block_cipher_core] ERROR");
    $finish;
  end

endmodule
